FILE: hdl/ccal_pkg.sv
// Shared types, constants and the month-length table for the calendar converter.
`default_nettype none

package ccal_pkg;

    // Field widths
    localparam int EPOCH_W = 31;
    localparam int TIME_W  = 32;
    localparam int DAYS_W  = 15;
    localparam int YEAR_W  = 11;

    // Time-zone offset in seconds per hour step
    localparam logic [15:0] SEC_PER_HOUR = 16'd3600;

    // Reciprocals for exact division of any 32-bit value by 60 and by 24
    localparam logic [31:0] RECIP_60 = 32'd2290649225;  // ceil(2^37 / 60)
    localparam logic [31:0] RECIP_24 = 32'd2863311531;  // ceil(2^36 / 24)
    localparam logic [5:0]  DIVISOR_60 = 6'd60;
    localparam logic [5:0]  DIVISOR_24 = 6'd24;

    // Calendar constants
    localparam logic [YEAR_W-1:0] BASE_YEAR      = 11'd1970;
    localparam logic [6:0]        BASE_YEAR_M100 = 7'd70;
    localparam logic [1:0]        BASE_CENT_M4   = 2'd3;   // century 19 mod 4
    localparam logic [6:0]        LAST_YEAR_M100 = 7'd99;
    localparam logic [7:0]        YEAR_BIAS_LOW  = 8'(2000 % 256);
    localparam logic [DAYS_W-1:0] DAYS_YEAR      = 15'd365;
    localparam logic [DAYS_W-1:0] DAYS_LEAP_YEAR = 15'd366;
    localparam logic [3:0]        MONTH_DEC      = 4'd11;

    // Divisor select for the constant divider
    typedef enum logic {
        DIV_BY_60,
        DIV_BY_24
    } div_code_t;

    // Control from the sequencer to the divider
    typedef struct packed {
        logic      load;
        div_code_t code;
    } div_ctrl_t;

    // Days in a month, month counted from 0
    function automatic logic [4:0] month_days(logic [3:0] mon, logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd1:                     len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ccal_cdiv.sv
// Constant divider by 60 or 24 through a registered reciprocal product.
`default_nettype none

module ccal_cdiv (
    input  wire                               clk,
    input  wire ccal_pkg::div_ctrl_t          ctrl,
    input  wire [ccal_pkg::TIME_W-1:0]        dividend,
    output logic [ccal_pkg::TIME_W-1:0]       quot,
    output logic [5:0]                        rem
);

    logic [ccal_pkg::TIME_W-1:0]   dividend_reg;
    ccal_pkg::div_code_t           code_reg;
    logic [2*ccal_pkg::TIME_W-1:0] prod_reg;
    logic [ccal_pkg::TIME_W-1:0]   recip;
    logic [5:0]                    divisor;
    logic [5:0]                    qd_low;

    // Pick the reciprocal for the requested divisor
    always_comb
    begin
        unique case (ctrl.code)
            ccal_pkg::DIV_BY_60: recip = ccal_pkg::RECIP_60;
            ccal_pkg::DIV_BY_24: recip = ccal_pkg::RECIP_24;
            default:             recip = ccal_pkg::RECIP_60;
        endcase
    end

    // Capture operand and product on load
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dividend_reg <= dividend;
            code_reg     <= ctrl.code;
            prod_reg     <= 64'(dividend) * 64'(recip);
        end
    end

    // Shift out the quotient, rebuild the remainder from the low bits
    always_comb
    begin
        unique case (code_reg)
            ccal_pkg::DIV_BY_60:
            begin
                quot    = {5'b0, prod_reg[63:37]};
                divisor = ccal_pkg::DIVISOR_60;
            end
            ccal_pkg::DIV_BY_24:
            begin
                quot    = {4'b0, prod_reg[63:36]};
                divisor = ccal_pkg::DIVISOR_24;
            end
            default:
            begin
                quot    = {5'b0, prod_reg[63:37]};
                divisor = ccal_pkg::DIVISOR_60;
            end
        endcase
        qd_low = 6'(quot[5:0] * divisor);
        rem    = 6'(dividend_reg[5:0] - qd_low);
    end

endmodule

`default_nettype wire

FILE: hdl/ccal_sub.sv
// Shared compare-and-subtract unit for the year and month walks.
`default_nettype none

module ccal_sub (
    input  wire  [ccal_pkg::DAYS_W-1:0] minuend,
    input  wire  [ccal_pkg::DAYS_W-1:0] subtrahend,
    output logic [ccal_pkg::DAYS_W-1:0] diff,
    output logic                        fits
);

    logic [ccal_pkg::DAYS_W:0] wide;

    // Subtract with borrow out; no borrow means the span fits
    always_comb
    begin
        wide = {1'b0, minuend} - {1'b0, subtrahend};
        diff = wide[ccal_pkg::DAYS_W-1:0];
        fits = ~wide[ccal_pkg::DAYS_W];
    end

endmodule

`default_nettype wire

FILE: hdl/epoch_seconds_to_calendar_unit.sv
// Top level: Unix seconds to local Gregorian date and time, sequenced.
//
//  channel   direction  handshake             payload
//  cfg       in         cfg_valid/cfg_ready   zone_offset_hours[3:0]
//  in        in         in_valid/in_ready     epoch_seconds[30:0]
//  out       out        out_valid/out_ready   second, minute, hour, day, month, year
//
// The year walk through the shared subtractor takes one year per cycle, over at most
// 68 whole years after 1970; the month walk then steps through month indices 0..11.
// Reset clears the sequencer, the output valid and sets the offset to 8 hours.
// in_ready is high only while idle; a finished result waits in its register,
// and a held result keeps the next one in its final state until taken.
// cfg_ready is always high.
`default_nettype none

module epoch_seconds_to_calendar_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [3:0]                          zone_offset_hours,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [ccal_pkg::EPOCH_W-1:0]        epoch_seconds,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [5:0]                          second_of_minute,
    output logic [5:0]                          minute_of_hour,
    output logic [4:0]                          hour_of_day,
    output logic [4:0]                          day_of_month,
    output logic [3:0]                          month_of_year,
    output logic [7:0]                          year_since_2000
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_SEC,
        S_SEC,
        S_MIN,
        S_HR,
        S_YEAR,
        S_MONTH,
        S_PUT
    } state_t;

    state_t                       state_reg;
    logic [3:0]                   zone_reg;
    logic [ccal_pkg::TIME_W-1:0]  time_reg;
    logic [5:0]                   sec_reg;
    logic [5:0]                   min_reg;
    logic [4:0]                   hr_reg;
    logic [ccal_pkg::DAYS_W-1:0]  days_reg;
    logic [ccal_pkg::YEAR_W-1:0]  year_reg;
    logic [6:0]                   yr_m100_reg;
    logic [1:0]                   cent_m4_reg;
    logic [3:0]                   mon_reg;
    logic                         out_valid_reg;
    logic [5:0]                   second_of_minute_reg;
    logic [5:0]                   minute_of_hour_reg;
    logic [4:0]                   hour_of_day_reg;
    logic [4:0]                   day_of_month_reg;
    logic [3:0]                   month_of_year_reg;
    logic [7:0]                   year_since_2000_reg;

    ccal_pkg::div_ctrl_t          div_ctrl;
    logic [ccal_pkg::TIME_W-1:0]  div_in;
    logic [ccal_pkg::TIME_W-1:0]  div_quot;
    logic [5:0]                   div_rem;
    logic [ccal_pkg::DAYS_W-1:0]  sub_b;
    logic [ccal_pkg::DAYS_W-1:0]  sub_diff;
    logic                         sub_fits;
    logic                         leap;
    logic                         in_fire;
    logic                         slot_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Gregorian leap rule from the running year counters
    assign leap = (year_reg[1:0] == 2'd0) && ((yr_m100_reg != 7'd0) || (cent_m4_reg == 2'd0));

    // Drive the divider during the three split steps
    always_comb
    begin
        div_ctrl.load = (state_reg == S_DIV_SEC) || (state_reg == S_SEC)
                        || (state_reg == S_MIN);
        div_ctrl.code = (state_reg == S_MIN) ? ccal_pkg::DIV_BY_24 : ccal_pkg::DIV_BY_60;
        div_in        = (state_reg == S_DIV_SEC) ? time_reg : div_quot;
    end

    ccal_cdiv u_cdiv (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (div_in),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Span to take off: month length in the month walk, year length otherwise
    always_comb
    begin
        if (state_reg == S_MONTH)
            sub_b = {10'b0, ccal_pkg::month_days(mon_reg, leap)};
        else
            sub_b = leap ? ccal_pkg::DAYS_LEAP_YEAR : ccal_pkg::DAYS_YEAR;
    end

    ccal_sub u_sub (
        .minuend    (days_reg),
        .subtrahend (sub_b),
        .diff       (sub_diff),
        .fits       (sub_fits)
    );

    // Sequencer, offset register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            zone_reg      <= 4'd8;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                zone_reg <= zone_offset_hours;

            // Drop the result once taken; the put step handles its own cycle
            if (out_valid_reg && out_ready && (state_reg != S_PUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        time_reg  <= 32'(epoch_seconds)
                                     + 32'(16'(zone_reg) * ccal_pkg::SEC_PER_HOUR);
                        state_reg <= S_DIV_SEC;
                    end
                end
                S_DIV_SEC:
                    state_reg <= S_SEC;
                S_SEC:
                begin
                    sec_reg   <= div_rem;
                    state_reg <= S_MIN;
                end
                S_MIN:
                begin
                    min_reg   <= div_rem;
                    state_reg <= S_HR;
                end
                S_HR:
                begin
                    hr_reg      <= div_rem[4:0];
                    days_reg    <= div_quot[ccal_pkg::DAYS_W-1:0];
                    year_reg    <= ccal_pkg::BASE_YEAR;
                    yr_m100_reg <= ccal_pkg::BASE_YEAR_M100;
                    cent_m4_reg <= ccal_pkg::BASE_CENT_M4;
                    state_reg   <= S_YEAR;
                end
                S_YEAR:
                begin
                    // Advance one whole year, or move on to the months
                    if (sub_fits)
                    begin
                        days_reg <= sub_diff;
                        year_reg <= 11'(year_reg + 11'd1);
                        if (yr_m100_reg == ccal_pkg::LAST_YEAR_M100)
                        begin
                            yr_m100_reg <= 7'd0;
                            cent_m4_reg <= 2'(cent_m4_reg + 2'd1);
                        end
                        else
                            yr_m100_reg <= 7'(yr_m100_reg + 7'd1);
                    end
                    else
                    begin
                        mon_reg   <= 4'd0;
                        state_reg <= S_MONTH;
                    end
                end
                S_MONTH:
                begin
                    // Advance one whole month; stop past December
                    if (sub_fits)
                    begin
                        days_reg <= sub_diff;
                        mon_reg  <= 4'(mon_reg + 4'd1);
                        if (mon_reg == ccal_pkg::MONTH_DEC)
                            state_reg <= S_PUT;
                    end
                    else
                        state_reg <= S_PUT;
                end
                S_PUT:
                begin
                    // Hold until the result register is free
                    if (slot_free)
                    begin
                        second_of_minute_reg <= sec_reg;
                        minute_of_hour_reg   <= min_reg;
                        hour_of_day_reg      <= hr_reg;
                        day_of_month_reg     <= 5'(days_reg[4:0] + 5'd1);
                        month_of_year_reg    <= 4'(mon_reg + 4'd1);
                        year_since_2000_reg  <= 8'(year_reg[7:0] - ccal_pkg::YEAR_BIAS_LOW);
                        out_valid_reg        <= 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign second_of_minute = second_of_minute_reg;
    assign minute_of_hour   = minute_of_hour_reg;
    assign hour_of_day      = hour_of_day_reg;
    assign day_of_month     = day_of_month_reg;
    assign month_of_year    = month_of_year_reg;
    assign year_since_2000  = year_since_2000_reg;

    // An accepted request keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> !in_ready)
        else $error("in_ready high right after a request was accepted");

    // The time split gives in-range fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60)
                      && (hour_of_day < 5'd24))
        else $error("time field out of range");

    // The month walk ends inside the year with a nonzero day
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_of_year != 4'd0) && (month_of_year <= 4'd12)
                      && (day_of_month != 5'd0))
        else $error("date field out of range");

    // The year walk never leaves more days than a leap year holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> (days_reg < ccal_pkg::DAYS_LEAP_YEAR))
        else $error("day count too large in month walk");

endmodule

`default_nettype wire
